// ===== sv/snq_pkg.sv =====
// Shared types, scale table and pitch-class helpers for the scale note quantizer.
`timescale 1ns / 1ps

package snq_pkg;

  localparam int unsigned PITCH_CLASSES = 12;
  localparam int unsigned SEARCH_SPAN   = 11;
  // search window holds offsets -SEARCH_SPAN..+SEARCH_SPAN around the note
  localparam int unsigned WIN_W         = 2 * SEARCH_SPAN + 1;
  localparam int unsigned NOTE_MAX      = 127;
  localparam int unsigned SCALE_COUNT   = 8;

  typedef logic [PITCH_CLASSES-1:0] pc_mask_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TONIC = 2'd0,
    CFG_SCALE = 2'd1,
    CFG_MODE  = 2'd2
  } cfg_idx_t;

  // mapping modes; the unused code acts as nearest
  typedef enum logic [1:0] {
    MODE_DOWN = 2'd0,
    MODE_UP   = 2'd1,
    MODE_NEAR = 2'd2
  } map_mode_t;

  typedef struct packed {
    logic [3:0] tonic;
    logic [2:0] scale_kind;
    logic [1:0] map_mode;
  } cfg_t;

  // pitch-class masks, bit p means p semitones above the tonic is allowed
  localparam pc_mask_t SCALE_MASKS [SCALE_COUNT] = '{
    12'h FFF,  // chromatic
    12'h AB5,  // major
    12'h 5AD,  // natural minor
    12'h 295,  // major pentatonic
    12'h 4A9,  // minor pentatonic
    12'h 4E9,  // blues
    12'h 6AD,  // dorian
    12'h 6B5   // mixolydian
  };

  // note mod 12 by restoring subtraction of 192, 96, 48, 24, 12
  function automatic logic [3:0] pc_of(input logic [7:0] note);
    logic [7:0] r;
    r = note;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    if (r >= 8'd12)  r = r - 8'd12;
    return r[3:0];
  endfunction

  // rotate a relative scale mask into absolute pitch classes (C = bit 0)
  function automatic pc_mask_t abs_mask(input pc_mask_t mask, input logic [3:0] tonic);
    logic [3:0]                   t;
    logic [2*PITCH_CLASSES-1:0]   dbl;
    t   = (tonic >= 4'd12) ? (tonic - 4'd12) : tonic;
    dbl = {mask, mask} << t;
    return dbl[2*PITCH_CLASSES-1:PITCH_CLASSES];
  endfunction

endpackage

// ===== sv/scale_note_quantizer.sv =====
// Throughput: one note per cycle while out_ready is high. The input register and
// the result register form a two-deep pipeline, so a new note is taken while a
// result waits to be taken, provided the input stage is empty.
// The search is one combinational pass between those two registers.
// Reset (rst_n low, synchronous) empties both stages and loads tonic 0,
// chromatic scale and nearest mode.
`timescale 1ns / 1ps

module scale_note_quantizer (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  // input note channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_note_in,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_note_out,
  output logic       out_status
);

  snq_pkg::cfg_t cfg;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_note_r;
  logic [7:0] s1_note_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [6:0] out_note_r;
  logic [6:0] out_note_nxt;
  logic       out_status_r;
  logic       out_status_nxt;

  logic       out_free;
  logic       s1_adv;
  logic [6:0] srch_note;
  logic       srch_status;

  snq_pkg::pc_mask_t out_amask;

  snq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  snq_search u_search (
    .note     (s1_note_r),
    .cfg      (cfg),
    .note_out (srch_note),
    .status   (srch_status)
  );

  // result stage frees up when empty or when its beat is taken
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // advance the pipeline
  always_comb begin
    s1_valid_nxt   = in_ready ? in_valid : s1_valid_r;
    s1_note_nxt    = (in_valid && in_ready) ? in_note_in : s1_note_r;
    out_valid_nxt  = out_free ? s1_valid_r : out_valid_r;
    out_note_nxt   = s1_adv ? srch_note : out_note_r;
    out_status_nxt = s1_adv ? srch_status : out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_note_r    <= s1_note_nxt;
    out_note_r   <= out_note_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_note_out = out_note_r;
  assign out_status   = out_status_r;

  // absolute scale mask for checking the result stage
  assign out_amask = snq_pkg::abs_mask(snq_pkg::SCALE_MASKS[cfg.scale_kind], cfg.tonic);

  // a not-found result carries note zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_note_r == 7'd0)
    else $error("not-found result with nonzero note");

  // a mapped note lies in the current scale
  a_mapped_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_status_r |->
      out_amask[snq_pkg::pc_of({1'b0, out_note_r})])
    else $error("mapped note outside the scale");

  // an accepted input beat occupies the input stage next cycle
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted beat lost in the input stage");

  // a blocked input stage holds its note
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_note_r))
    else $error("input stage changed while blocked");

  // the result stage loads whenever the input stage advances
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat did not reach the result stage");

endmodule

// ===== sv/snq_cfg_regs.sv =====
// Configuration register file: tonic, scale kind and mapping mode.
`timescale 1ns / 1ps

module snq_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output snq_pkg::cfg_t      cfg
);

  snq_pkg::cfg_t cfg_r;
  snq_pkg::cfg_t cfg_nxt;

  // writes are always accepted and take effect from the next cycle
  assign cfg_ready = 1'b1;
  assign cfg        = cfg_r;

  // decode the write beat; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (snq_pkg::cfg_idx_t'(cfg_index))
        snq_pkg::CFG_TONIC: cfg_nxt.tonic      = cfg_data;
        snq_pkg::CFG_SCALE: cfg_nxt.scale_kind = cfg_data[2:0];
        snq_pkg::CFG_MODE:  cfg_nxt.map_mode   = cfg_data[1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tonic      <= 4'd0;
      cfg_r.scale_kind <= 3'd0;
      cfg_r.map_mode   <= snq_pkg::MODE_NEAR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/snq_search.sv =====
// Single-pass note search: window of allowed neighbors and priority pick.
`timescale 1ns / 1ps

module snq_search (
  input  logic [7:0]     note,
  input  snq_pkg::cfg_t  cfg,
  output logic [6:0]     note_out,
  output logic           status
);

  localparam int unsigned SPAN  = snq_pkg::SEARCH_SPAN;
  localparam int unsigned WIN_W = snq_pkg::WIN_W;
  localparam int unsigned EXT_W = 3 * snq_pkg::PITCH_CLASSES;

  snq_pkg::pc_mask_t   amask;
  logic [3:0]          pcn;
  logic [EXT_W-1:0]    ext;
  logic [EXT_W-1:0]    ext_sh;
  logic [WIN_W-1:0]    in_range;
  logic [WIN_W-1:0]    win;
  logic                use_lo;
  logic                use_hi;

  // absolute scale mask and the pitch class of the note
  assign amask  = snq_pkg::abs_mask(snq_pkg::SCALE_MASKS[cfg.scale_kind], cfg.tonic);
  assign pcn    = snq_pkg::pc_of(note);
  assign ext    = {amask, amask, amask};
  // bit k of the window is offset k-SPAN; its class sits at pcn+k+1 in ext
  assign ext_sh = ext >> ({1'b0, pcn} + 5'd1);

  // keep only candidates within 0..127
  always_comb begin
    for (int k = 0; k < WIN_W; k++) begin
      in_range[k] = ({2'b00, note} + 10'(k) >= 10'(SPAN)) &&
                    ({2'b00, note} + 10'(k) <= 10'(SPAN + snq_pkg::NOTE_MAX));
    end
  end

  assign win    = ext_sh[WIN_W-1:0] & in_range;
  assign use_lo = (cfg.map_mode != snq_pkg::MODE_UP);
  assign use_hi = (cfg.map_mode != snq_pkg::MODE_DOWN);

  // pick the smallest distance; lower wins a tie, the note itself wins outright
  always_comb begin
    note_out = 7'd0;
    status   = 1'b1;
    for (int d = SPAN; d >= 1; d--) begin
      if (use_hi && win[SPAN + d]) begin
        note_out = note[6:0] + 7'(d);
        status   = 1'b0;
      end
      if (use_lo && win[SPAN - d]) begin
        note_out = note[6:0] - 7'(d);
        status   = 1'b0;
      end
    end
    if (win[SPAN]) begin
      note_out = note[6:0];
      status   = 1'b0;
    end
  end

endmodule
